// ===== rtl/core/flywheel_speed_pi_controller_core_defines.svh =====
// assertion macros for the flywheel speed controller
`ifndef FLYWHEEL_SPEED_PI_CONTROLLER_CORE_DEFINES_SVH
`define FLYWHEEL_SPEED_PI_CONTROLLER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define FSPC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fspc assertion failed");
`define FSPC_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("fspc forbidden condition seen");
`else
`define FSPC_ASSERT(label, clk, rst, prop)
`define FSPC_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== rtl/core/fspc_pkg.sv =====
// shared types and constants of the flywheel speed controller
package fspc_pkg;

  localparam int NUM_BITS = 32;
  localparam int GAIN_BITS = 24;
  localparam int ERR_BITS = 17;
  localparam int DUTY_BITS = 7;
  localparam int SPEED_BITS = 16;
  localparam int SETPOINT_BITS = 8;
  localparam int DUTY_MAX = 100;

  localparam logic [1:0] KIND_EDGE = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_SET = 2'd2;

  localparam logic [1:0] REG_SPEED_NUMERATOR = 2'd0;
  localparam logic [1:0] REG_KP_GAIN = 2'd1;
  localparam logic [1:0] REG_KI_GAIN = 2'd2;

  localparam logic [NUM_BITS-1:0] SPEED_NUMERATOR_RESET = 32'd13333333;
  localparam logic [GAIN_BITS-1:0] KP_GAIN_RESET = 24'd1310720;
  localparam logic [GAIN_BITS-1:0] KI_GAIN_RESET = 24'd3277;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

// ===== rtl/core/fspc_div.sv =====
// restoring serial divider, one quotient bit per cycle, saturated to 16 bits
module fspc_div #(
  parameter int TIME_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [fspc_pkg::NUM_BITS-1:0] numer,
  input  logic [TIME_BITS-1:0]      denom,
  output fspc_pkg::unit_status_t    status,
  output logic [fspc_pkg::SPEED_BITS-1:0] quot
);

  localparam int NB = fspc_pkg::NUM_BITS;
  localparam int CNT_W = $clog2(NB + 1);
  localparam int SB = fspc_pkg::SPEED_BITS;

  logic [CNT_W-1:0]     cnt;
  logic                 done;
  logic [TIME_BITS-1:0] rem;
  logic [TIME_BITS-1:0] dreg;
  logic [NB-1:0]        n;
  logic [TIME_BITS:0]   shifted;
  logic [TIME_BITS+1:0] sub;
  logic                 borrow;
  logic [TIME_BITS-1:0] rem_next;

  assign shifted = {rem, n[NB-1]};
  assign sub = {1'b0, shifted} - {2'b00, dreg};
  assign borrow = sub[TIME_BITS+1];
  assign rem_next = borrow ? shifted[TIME_BITS-1:0] : sub[TIME_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && cnt == '0) begin
        cnt <= CNT_W'(NB);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && cnt == '0) begin
      rem <= '0;
      dreg <= denom;
      n <= numer;
    end else if (cnt != '0) begin
      rem <= rem_next;
      n <= {n[NB-2:0], ~borrow};
    end
  end

  assign status.busy = (cnt != '0);
  assign status.done = done;
  assign quot = (|n[NB-1:SB]) ? {SB{1'b1}} : n[SB-1:0];

endmodule

// ===== rtl/core/fspc_pi.sv =====
// incremental pi step on one shared multiplier with clamp to the duty range
module fspc_pi #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [fspc_pkg::GAIN_BITS-1:0]        kp_gain,
  input  logic [fspc_pkg::GAIN_BITS-1:0]        ki_gain,
  input  logic signed [fspc_pkg::ERR_BITS-1:0]  err,
  input  logic signed [fspc_pkg::ERR_BITS-1:0]  err_prev,
  input  logic [fspc_pkg::DUTY_BITS+FRAC_BITS-1:0] u_prev,
  output fspc_pkg::unit_status_t                status,
  output logic [fspc_pkg::DUTY_BITS+FRAC_BITS-1:0] u_out
);

  localparam int CW = fspc_pkg::DUTY_BITS + FRAC_BITS;
  localparam int GW = fspc_pkg::GAIN_BITS + 2;
  localparam int EW = fspc_pkg::ERR_BITS;
  localparam int PW = GW + EW;
  localparam int AW = PW + 2;
  localparam logic signed [AW-1:0] TOP = AW'(fspc_pkg::DUTY_MAX) <<< FRAC_BITS;

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_MUL2 = 2'd1;
  localparam logic [1:0] P_SUB = 2'd2;
  localparam logic [1:0] P_CLAMP = 2'd3;

  logic [1:0]            step;
  logic                  done;
  logic signed [GW-1:0]  gsum;
  logic signed [GW-1:0]  gdiff;
  logic signed [GW-1:0]  ma;
  logic signed [EW-1:0]  mb;
  logic signed [PW-1:0]  prod;
  logic signed [AW-1:0]  acc;
  logic signed [AW-1:0]  u_prev_ext;
  logic [CW-1:0]         clamped;

  assign gsum = $signed({2'b00, kp_gain} + {2'b00, ki_gain});
  assign gdiff = $signed({2'b00, kp_gain} - {2'b00, ki_gain});
  assign ma = (step == P_IDLE) ? gsum : gdiff;
  assign mb = (step == P_IDLE) ? err : err_prev;
  assign u_prev_ext = $signed({{(AW-CW){1'b0}}, u_prev});

  always_comb begin
    if (acc < 0) begin
      clamped = '0;
    end else if (acc > TOP) begin
      clamped = TOP[CW-1:0];
    end else begin
      clamped = acc[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= P_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (step)
        P_IDLE: begin
          if (start) begin
            step <= P_MUL2;
          end
        end
        P_MUL2: step <= P_SUB;
        P_SUB: step <= P_CLAMP;
        P_CLAMP: begin
          step <= P_IDLE;
          done <= 1'b1;
        end
        default: step <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (step)
      P_IDLE: begin
        if (start) begin
          prod <= ma * mb;
        end
      end
      P_MUL2: begin
        acc <= u_prev_ext + AW'(prod);
        prod <= ma * mb;
      end
      P_SUB: acc <= acc - AW'(prod);
      P_CLAMP: u_out <= clamped;
      default: ;
    endcase
  end

  assign status.busy = (step != P_IDLE);
  assign status.done = done;

endmodule

// ===== rtl/core/flywheel_speed_pi_controller_core.sv =====
// flywheel speed controller top level: period measurement and incremental pi duty
// encoder edge: speed from the 32-step serial divider, which a zero period skips
// control tick: four steps of the shared multiplier and clamp sequencer
// set command, disabled tick and unused kind skip both units; one request in flight at a time
// synchronous reset clears the control state, gains and numerator return to their defaults
`include "flywheel_speed_pi_controller_core_defines.svh"
module flywheel_speed_pi_controller_core #(
  parameter int FRAC_BITS = 16,
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] capture_time,
  input  logic [7:0]  command,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  duty,
  output logic [15:0] speed,
  output logic        running,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int CW = fspc_pkg::DUTY_BITS + FRAC_BITS;
  localparam int EW = fspc_pkg::ERR_BITS;
  localparam int GB = fspc_pkg::GAIN_BITS;
  localparam logic [CW-1:0] TOP = CW'(fspc_pkg::DUTY_MAX) << FRAC_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV = 2'd1;
  localparam logic [1:0] S_PI = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                  state;
  logic [31:0]                 speed_numerator;
  logic [GB-1:0]               kp_gain;
  logic [GB-1:0]               ki_gain;
  logic [TIME_BITS-1:0]        last_edge_time;
  logic [15:0]                 measured_speed;
  logic [7:0]                  setpoint;
  logic                        enabled;
  logic signed [EW-1:0]        previous_error;
  logic [CW-1:0]               previous_control;
  logic [6:0]                  duty_value;

  logic                        accept;
  logic [TIME_BITS-1:0]        cap;
  logic [TIME_BITS-1:0]        diff;
  logic signed [EW-1:0]        err;
  logic                        div_start;
  logic                        pi_start;
  fspc_pkg::unit_status_t      div_stat;
  fspc_pkg::unit_status_t      pi_stat;
  logic [15:0]                 div_quot;
  logic [CW-1:0]               pi_u;

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept = in_valid && in_ready;
  assign cap = capture_time[TIME_BITS-1:0];
  assign diff = cap - last_edge_time;
  assign err = $signed({1'b0, 8'd0, setpoint}) - $signed({1'b0, measured_speed});
  assign div_start = accept && kind == fspc_pkg::KIND_EDGE && diff != '0;
  assign pi_start = accept && kind == fspc_pkg::KIND_TICK && enabled;

  fspc_div #(
    .TIME_BITS(TIME_BITS)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .numer(speed_numerator),
    .denom(diff),
    .status(div_stat),
    .quot(div_quot)
  );

  fspc_pi #(
    .FRAC_BITS(FRAC_BITS)
  ) u_pi (
    .clk(clk),
    .rst(rst),
    .start(pi_start),
    .kp_gain(kp_gain),
    .ki_gain(ki_gain),
    .err(err),
    .err_prev(previous_error),
    .u_prev(previous_control),
    .status(pi_stat),
    .u_out(pi_u)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      speed_numerator <= fspc_pkg::SPEED_NUMERATOR_RESET;
      kp_gain <= fspc_pkg::KP_GAIN_RESET;
      ki_gain <= fspc_pkg::KI_GAIN_RESET;
      last_edge_time <= '0;
      measured_speed <= '0;
      setpoint <= '0;
      enabled <= 1'b0;
      previous_error <= '0;
      previous_control <= '0;
      duty_value <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fspc_pkg::REG_SPEED_NUMERATOR: speed_numerator <= cfg_data;
          fspc_pkg::REG_KP_GAIN: kp_gain <= cfg_data[GB-1:0];
          fspc_pkg::REG_KI_GAIN: ki_gain <= cfg_data[GB-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_DONE;
            case (kind)
              fspc_pkg::KIND_EDGE: begin
                last_edge_time <= cap;
                if (diff != '0) begin
                  state <= S_DIV;
                end
              end
              fspc_pkg::KIND_TICK: begin
                if (enabled) begin
                  state <= S_PI;
                end
              end
              fspc_pkg::KIND_SET: begin
                setpoint <= command;
                enabled <= (command != 8'd0);
                if (command == 8'd0) begin
                  duty_value <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            measured_speed <= div_quot;
            state <= S_DONE;
          end
        end
        S_PI: begin
          if (pi_stat.done) begin
            previous_error <= err;
            previous_control <= pi_u;
            duty_value <= pi_u[FRAC_BITS +: fspc_pkg::DUTY_BITS];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      duty <= duty_value;
      speed <= measured_speed;
      running <= enabled;
    end
  end

  `FSPC_ASSERT(a_div_done_in_div, clk, rst, div_stat.done |-> state == S_DIV)
  `FSPC_ASSERT(a_pi_done_in_pi, clk, rst, pi_stat.done |-> state == S_PI)
  `FSPC_ASSERT(a_div_alive, clk, rst, state == S_DIV |-> div_stat.busy || div_stat.done)
  `FSPC_ASSERT(a_pi_alive, clk, rst, state == S_PI |-> pi_stat.busy || pi_stat.done)
  `FSPC_ASSERT(a_running_setpoint, clk, rst, enabled == (setpoint != 8'd0))
  `FSPC_ASSERT_NEVER(a_control_range, clk, rst, previous_control > TOP)

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the flywheel speed pi controller core
`timescale 1ns / 100ps

module testbench;

  localparam int FRAC_BITS = 16;
  localparam int TIME_BITS = 32;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLDOFF_CYCLES = 200;
  localparam int SETTLE_CYCLES = 40;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [fspc_pkg::DUTY_BITS-1:0]  duty;
    logic [fspc_pkg::SPEED_BITS-1:0] speed;
    logic                            running;
  } drive_status_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = fspc_pkg::KIND_TICK;
  logic [31:0] capture_time = '0;
  logic [7:0]  command = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  duty;
  logic [15:0] speed;
  logic        running;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = fspc_pkg::REG_SPEED_NUMERATOR;
  logic [31:0] cfg_data = '0;

  // controller image kept alongside the core
  logic [fspc_pkg::NUM_BITS-1:0]      num_cfg = fspc_pkg::SPEED_NUMERATOR_RESET;
  logic [fspc_pkg::GAIN_BITS-1:0]     kp_cfg = fspc_pkg::KP_GAIN_RESET;
  logic [fspc_pkg::GAIN_BITS-1:0]     ki_cfg = fspc_pkg::KI_GAIN_RESET;
  logic [TIME_BITS-1:0]               img_edge_time = '0;
  logic [fspc_pkg::SPEED_BITS-1:0]    img_speed = '0;
  logic [fspc_pkg::SETPOINT_BITS-1:0] img_setpoint = '0;
  logic                               img_enabled = 1'b0;
  longint                             img_prev_err = 0;
  longint                             img_prev_drive = 0;
  logic [fspc_pkg::DUTY_BITS-1:0]     img_duty = '0;

  drive_status_t pending_status[$];
  int            mismatch_count = 0;
  bit            tx_idle_en = 1'b1;
  bit            rx_idle_en = 1'b1;
  logic          holdoff_on = 1'b0;
  int            rx_stall_left = 0;
  logic [31:0]   edge_clock = '0;
  event          start_holdoff;

  flywheel_speed_pi_controller_core #(
    .FRAC_BITS(FRAC_BITS),
    .TIME_BITS(TIME_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .capture_time(capture_time),
    .command(command),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .duty(duty),
    .speed(speed),
    .running(running),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic drive_status_t predict_drive_status(logic [1:0] k, logic [31:0] t,
                                                         logic [7:0] c);
    logic [TIME_BITS-1:0] period;
    logic [31:0]          quot;
    longint               sp, meas, kp, ki, err, drive, top;
    drive_status_t        st;
    case (k)
      fspc_pkg::KIND_EDGE: begin
        period = t[TIME_BITS-1:0] - img_edge_time;
        if (period != 0) begin
          quot = num_cfg / period;
          img_speed = (quot > 32'd65535) ? 16'hFFFF : quot[15:0];
        end
        img_edge_time = t[TIME_BITS-1:0];
      end
      fspc_pkg::KIND_TICK: begin
        if (img_enabled) begin
          sp = longint'(img_setpoint);
          meas = longint'(img_speed);
          kp = longint'(kp_cfg);
          ki = longint'(ki_cfg);
          top = longint'(fspc_pkg::DUTY_MAX) <<< FRAC_BITS;
          err = sp - meas;
          drive = img_prev_drive + (kp + ki) * err - (kp - ki) * img_prev_err;
          if (drive > top) drive = top;
          else if (drive < 0) drive = 0;
          img_prev_err = err;
          img_prev_drive = drive;
          img_duty = drive[FRAC_BITS +: fspc_pkg::DUTY_BITS];
        end
      end
      fspc_pkg::KIND_SET: begin
        img_setpoint = c;
        if (c != 0) begin
          img_enabled = 1'b1;
        end else begin
          img_enabled = 1'b0;
          img_duty = '0;
        end
      end
      default: ;
    endcase
    st.duty = img_duty;
    st.speed = img_speed;
    st.running = img_enabled;
    return st;
  endfunction

  // output side: random stalls plus the long hold-off
  always @(posedge clk) begin
    if (holdoff_on) begin
      out_ready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      out_ready <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      rx_stall_left <= $urandom_range(0, 8);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial forever begin
    @(start_holdoff);
    holdoff_on <= 1'b1;
    repeat (HOLDOFF_CYCLES) @(posedge clk);
    holdoff_on <= 1'b0;
  end

  always @(posedge clk) begin
    drive_status_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected status: duty %0d speed %0d running %0d", duty, speed, running);
      end else begin
        want = pending_status.pop_front();
        if (duty !== want.duty || speed !== want.speed || running !== want.running) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("status differs at %0t: exp duty %0d speed %0d running %0d, got %0d %0d %0d",
                     $realtime, want.duty, want.speed, want.running, duty, speed, running);
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // valid stays high after acceptance until the next call or a drain lowers it
  task automatic send_request(logic [1:0] k, logic [31:0] t, logic [7:0] c);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    capture_time <= t;
    command <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_status.push_back(predict_drive_status(k, t, c));
  endtask

  task automatic drain_requests();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      fspc_pkg::REG_SPEED_NUMERATOR: num_cfg = value;
      fspc_pkg::REG_KP_GAIN:         kp_cfg = value[fspc_pkg::GAIN_BITS-1:0];
      fspc_pkg::REG_KI_GAIN:         ki_cfg = value[fspc_pkg::GAIN_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [31:0] num, logic [31:0] kp_word, logic [31:0] ki_word);
    drain_requests();
    cfg_write(fspc_pkg::REG_SPEED_NUMERATOR, num);
    cfg_write(fspc_pkg::REG_KP_GAIN, kp_word);
    cfg_write(fspc_pkg::REG_KI_GAIN, ki_word);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // command, then a mix of plausible encoder edges, ticks and new commands, with some noise
  task automatic drive_flywheel(int n_items, int noise_pct);
    logic [7:0]  target;
    logic [31:0] period;
    logic [1:0]  k;
    logic [31:0] t;
    logic [7:0]  c;
    int          roll;
    int          spd;
    target = 8'($urandom_range(1, 255));
    send_request(fspc_pkg::KIND_SET, $urandom, target);
    for (int i = 1; i < n_items; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < noise_pct) begin
        k = 2'($urandom_range(0, 3));
        t = $urandom;
        c = 8'($urandom_range(0, 255));
        if (k == fspc_pkg::KIND_EDGE) edge_clock = t;
        if (k == fspc_pkg::KIND_SET && c != 0) target = c;
        send_request(k, t, c);
      end else if (roll < 50) begin
        spd = int'(target) + int'($urandom_range(0, 40)) - 20;
        if (spd < 1) spd = 1;
        if (num_cfg == 0) period = $urandom_range(1, 1 << 20);
        else period = num_cfg / spd;
        if (period == 0) period = $urandom_range(0, 2);
        if ($urandom_range(0, 49) == 0) period = 0;
        edge_clock += period;
        send_request(fspc_pkg::KIND_EDGE, edge_clock, 8'($urandom));
      end else if (roll < 94) begin
        send_request(fspc_pkg::KIND_TICK, $urandom, 8'($urandom));
      end else begin
        target = 8'($urandom_range(1, 255));
        send_request(fspc_pkg::KIND_SET, $urandom, target);
      end
    end
  endtask

  task automatic test_directed_cases();
    send_request(fspc_pkg::KIND_TICK, 32'h0, 8'h0);
    send_request(KIND_UNUSED, 32'hFFFFFFFF, 8'hFF);
    send_request(fspc_pkg::KIND_EDGE, 32'h0, 8'h0);
    send_request(fspc_pkg::KIND_EDGE, 32'd133333, 8'h0);
    send_request(fspc_pkg::KIND_EDGE, 32'd133333, 8'h0);
    send_request(fspc_pkg::KIND_EDGE, 32'd133334, 8'h0);
    send_request(fspc_pkg::KIND_EDGE, 32'hFFFFFFFF, 8'h0);
    send_request(fspc_pkg::KIND_EDGE, 32'h0, 8'h0);
    send_request(fspc_pkg::KIND_EDGE, 32'd133333, 8'h0);
    send_request(fspc_pkg::KIND_SET, 32'h0, 8'd255);
    send_request(fspc_pkg::KIND_TICK, 32'hFFFFFFFF, 8'h0);
    send_request(fspc_pkg::KIND_TICK, 32'h0, 8'h0);
    send_request(fspc_pkg::KIND_EDGE, 32'd666665, 8'h0);
    send_request(fspc_pkg::KIND_SET, 32'h0, 8'd1);
    send_request(fspc_pkg::KIND_TICK, 32'h0, 8'h0);
    send_request(fspc_pkg::KIND_SET, 32'h0, 8'd0);
    send_request(fspc_pkg::KIND_TICK, 32'h0, 8'h0);
    send_request(fspc_pkg::KIND_SET, 32'h0, 8'd128);
    send_request(fspc_pkg::KIND_EDGE, 32'd800000, 8'h0);
    send_request(fspc_pkg::KIND_TICK, 32'h0, 8'h0);
    send_request(fspc_pkg::KIND_TICK, 32'h0, 8'h0);
    send_request(KIND_UNUSED, 32'h0, 8'h0);
    edge_clock = 32'd800000;
  endtask

  task automatic test_register_extremes();
    configure(32'h0, fspc_pkg::KP_GAIN_RESET, fspc_pkg::KI_GAIN_RESET);
    send_request(fspc_pkg::KIND_EDGE, edge_clock + 32'd1, 8'h0);
    send_request(fspc_pkg::KIND_EDGE, edge_clock + 32'd1, 8'h0);
    edge_clock += 32'd1;
    drive_flywheel(20, 10);
    configure(32'hFFFFFFFF, 32'hFF_FFFFFF, 32'h00_FFFFFF);
    drive_flywheel(30, 10);
    configure(32'd1, 32'h0, 32'hFFFFFFFF);
    send_request(fspc_pkg::KIND_EDGE, edge_clock + 32'd1, 8'h0);
    edge_clock += 32'd1;
    drive_flywheel(30, 10);
    configure(32'd1, 32'h00_FFFFFF, 32'h0);
    drive_flywheel(30, 10);
    // index past the register list must leave everything alone
    drain_requests();
    cfg_write(REG_UNUSED, $urandom);
    cfg_write(fspc_pkg::REG_SPEED_NUMERATOR, fspc_pkg::SPEED_NUMERATOR_RESET);
    cfg_write(fspc_pkg::REG_KP_GAIN, 32'h0);
    cfg_write(fspc_pkg::REG_KI_GAIN, 32'h0);
    cfg_write(REG_UNUSED, 32'hFFFFFFFF);
    cfg_valid <= 1'b0;
    @(posedge clk);
    drive_flywheel(25, 10);
  endtask

  task automatic test_output_holdoff();
    configure(fspc_pkg::SPEED_NUMERATOR_RESET, fspc_pkg::KP_GAIN_RESET,
              fspc_pkg::KI_GAIN_RESET);
    -> start_holdoff;
    drive_flywheel(30, 5);
    drain_requests();
  endtask

  task automatic test_random_control(int phases, int per_phase);
    logic [31:0] num;
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(0, 2))
        0: num = fspc_pkg::SPEED_NUMERATOR_RESET;
        1: num = $urandom_range(1000000, 100000000);
        default: num = $urandom;
      endcase
      configure(num,
                {8'($urandom_range(0, 255)), 24'($urandom_range(0, 24'h0FFFFF))},
                {8'($urandom_range(0, 255)), 24'($urandom_range(0, 24'h00FFFF))});
      for (int s = 0; s < per_phase / 40; s++) drive_flywheel(40, 8);
    end
  endtask

  task automatic test_no_idle();
    drain_requests();
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    configure(fspc_pkg::SPEED_NUMERATOR_RESET, 32'h0002_0000, 32'h0000_0400);
    for (int s = 0; s < 5; s++) drive_flywheel(40, 8);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_register_extremes();
    test_output_holdoff();
    test_random_control(6, 240);
    test_no_idle();
    drain_requests();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_status.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
